// File: src/pgalloc_pkg.sv
// Shared widths, command and status codes, and request/response types of the page allocator.
package pgalloc_pkg;

    // Fixed field widths
    localparam int PAGE_W   = 15;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int REF_W    = 8;

    // Defaults for the top-level parameters
    localparam int NUM_PAGES_DEF   = 32768;
    localparam int COUNT_WIDTH_DEF = 8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADDREF = 2'd2;
    localparam logic [CMD_W-1:0] CMD_COW    = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT      = 3'd4;

    // Classified request as queued for the back end
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] page;
        logic              bad;
    } pgalloc_req_t;

    // One response item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   result_page;
        logic                copy_needed;
        logic                page_released;
        logic [REF_W-1:0]    ref_count;
    } pgalloc_resp_t;

endpackage

// File: src/page_allocator_with_ref_counts.sv
// Path: an accepted request passes through the queue entry, the count and stack RAM reads and the result register.
// Throughput: the back end runs one request at a time, with an extra write state for a copy-on-write that
//   hands out a new page; set by the read-modify-write of the single-write-port count RAM.
// Reset: the count RAM is cleared one entry per cycle, over all NUM_PAGES entries, with in_ready low;
//   configuration writes are taken at any time. first_page resets to 0.
// Top level of the page frame allocator with reference counts.
module page_allocator_with_ref_counts
    import pgalloc_pkg::*;
#(
    parameter int NUM_PAGES   = NUM_PAGES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PAGE_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic [PAGE_W-1:0]   page,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [PAGE_W-1:0]   result_page,
    output logic                copy_needed,
    output logic                page_released,
    output logic [REF_W-1:0]    ref_count
);

    logic [PAGE_W-1:0] first_page_reg, first_page_next;
    logic              clearing;
    logic              q_full, q_valid, q_pop, push;
    pgalloc_req_t      push_req, q_head;
    pgalloc_resp_t     resp;

    // Configuration register
    assign cfg_ready       = 1'b1;
    assign first_page_next = (cfg_valid && cfg_ready) ? cfg_data : first_page_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg <= '0;
        end
        else
        begin
            first_page_reg <= first_page_next;
        end
    end

    pgalloc_front #(
        .NUM_PAGES (NUM_PAGES)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .page       (page),
        .first_page (first_page_reg),
        .clearing   (clearing),
        .q_full     (q_full),
        .push       (push),
        .push_req   (push_req)
    );

    pgalloc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    pgalloc_back #(
        .NUM_PAGES   (NUM_PAGES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .first_page (first_page_reg),
        .q_valid    (q_valid),
        .q_req      (q_head),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_resp   (resp)
    );

    assign status        = resp.status;
    assign result_page   = resp.result_page;
    assign copy_needed   = resp.copy_needed;
    assign page_released = resp.page_released;
    assign ref_count     = resp.ref_count;

    // No request enters while the count table is being cleared
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("request accepted during count clear");

    // Any error reports no page and no side effect flags
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (result_page == '0 && !copy_needed && !page_released))
        else $error("error result carries page or flags");

    // A released page has no references left
    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && page_released) |-> (ref_count == '0 && status == ST_OK))
        else $error("released page with nonzero count");

    // A copy target starts with exactly one reference
    a_copy_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && copy_needed) |-> (ref_count == REF_W'(1) && status == ST_OK))
        else $error("copy-on-write page count not one");

endmodule

// File: src/pgalloc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pgalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/pgalloc_front.sv
// Front end: takes requests, flags bad page indices and pushes them into the queue.
module pgalloc_front
    import pgalloc_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  command,
    input  logic [PAGE_W-1:0] page,
    input  logic [PAGE_W-1:0] first_page,
    input  logic              clearing,
    input  logic              q_full,
    output logic              push,
    output pgalloc_req_t      push_req
);

    localparam int MARK_W = $clog2(NUM_PAGES + 1);
    localparam int LIM_W  = (PAGE_W > MARK_W) ? PAGE_W : MARK_W;

    logic below_first;
    logic above_last;

    // Range check of the addressed page (allocate ignores the page)
    assign below_first = page < first_page;
    assign above_last  = LIM_W'(page) >= LIM_W'(NUM_PAGES);

    // No request while the count table is being cleared
    assign in_ready = !q_full && !clearing;
    assign push     = in_valid && in_ready;

    assign push_req.cmd  = command;
    assign push_req.page = page;
    assign push_req.bad  = (command != CMD_ALLOC) && (below_first || above_last);

endmodule

// File: src/pgalloc_fifo.sv
// Short request queue between front and back end.
module pgalloc_fifo
    import pgalloc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  pgalloc_req_t push_req,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output pgalloc_req_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pgalloc_req_t     entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full   = count_reg == CNT_W'(QUEUE_DEPTH);
    assign valid  = count_reg != '0;
    assign head   = entries[rd_ptr_reg];
    assign do_pop = pop && valid;

    // Pointer and fill-count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// File: src/pgalloc_back.sv
// Back end: clears the count table, then runs each request against the count and stack RAMs.
module pgalloc_back
    import pgalloc_pkg::*;
#(
    parameter int NUM_PAGES   = NUM_PAGES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PAGE_W-1:0] first_page,
    input  logic              q_valid,
    input  pgalloc_req_t      q_req,
    output logic              q_pop,
    output logic              clearing,
    output logic              out_valid,
    input  logic              out_ready,
    output pgalloc_resp_t     out_resp
);

    localparam int IDX_W  = $clog2(NUM_PAGES);
    localparam int MARK_W = $clog2(NUM_PAGES + 1);
    localparam int EXT_W  = (PAGE_W > IDX_W) ? PAGE_W : IDX_W;
    localparam int LIM_W  = (PAGE_W > MARK_W) ? PAGE_W : MARK_W;
    localparam int CX_W   = (COUNT_WIDTH > REF_W) ? COUNT_WIDTH : REF_W;

    // Sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_COW2  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       clr_idx_reg, clr_idx_next;
    logic [MARK_W-1:0]      top_reg, top_next;
    logic [MARK_W-1:0]      mark_reg, mark_next;
    logic                   out_valid_reg, out_valid_next;
    pgalloc_req_t           req_reg, req_next;
    pgalloc_resp_t          resp_reg, resp_next;
    logic [IDX_W-1:0]       cow_page_reg, cow_page_next;
    logic [COUNT_WIDTH-1:0] cow_cnt_reg, cow_cnt_next;

    // RAM ports
    logic                   cnt_we, cnt_re;
    logic [IDX_W-1:0]       cnt_waddr, cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
    logic                   stk_we, stk_re;
    logic [IDX_W-1:0]       stk_waddr, stk_raddr;
    logic [IDX_W-1:0]       stk_wdata, stk_rdata;

    // Datapath helpers
    logic [EXT_W-1:0]       page_ext, qpage_ext, np_ext;
    logic [IDX_W-1:0]       pidx, qpidx, np, fresh_pg;
    logic [PAGE_W-1:0]      np_page;
    logic [MARK_W-1:0]      top_m1, mark_m1;
    logic                   have_stack, have_fresh, can_take, stack_room;
    logic [COUNT_WIDTH-1:0] c, c_dec, c_inc;
    logic                   c_zero, c_max, c_le1, go;

    // Low REF_W bits of a count, zero-extended when the count is narrower
    function automatic logic [REF_W-1:0] to_ref(input logic [COUNT_WIDTH-1:0] v);
        logic [CX_W-1:0] x;
        x = CX_W'(v);
        return x[REF_W-1:0];
    endfunction

    pgalloc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_PAGES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    pgalloc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Index forms of the page fields
    assign page_ext  = EXT_W'(req_reg.page);
    assign pidx      = page_ext[IDX_W-1:0];
    assign qpage_ext = EXT_W'(q_req.page);
    assign qpidx     = qpage_ext[IDX_W-1:0];

    // Free-page selection: returned pages first, then fresh pages downward
    assign top_m1     = top_reg - 1'b1;
    assign mark_m1    = mark_reg - 1'b1;
    assign fresh_pg   = mark_m1[IDX_W-1:0];
    assign have_stack = top_reg != '0;
    assign have_fresh = LIM_W'(mark_reg) > LIM_W'(first_page);
    assign can_take   = have_stack || have_fresh;
    assign np         = have_stack ? stk_rdata : fresh_pg;
    assign np_ext     = EXT_W'(np);
    assign np_page    = np_ext[PAGE_W-1:0];
    assign stack_room = top_reg < MARK_W'(NUM_PAGES);

    // Count arithmetic on the read-back value
    assign c      = cnt_rdata;
    assign c_dec  = c - 1'b1;
    assign c_inc  = c + 1'b1;
    assign c_zero = c == '0;
    assign c_max  = c == {COUNT_WIDTH{1'b1}};
    assign c_le1  = c <= COUNT_WIDTH'(1);

    // Result register free or being emptied this cycle
    assign go = !out_valid_reg || out_ready;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        top_next       = top_reg;
        mark_next      = mark_reg;
        out_valid_next = out_valid_reg && !out_ready;
        req_next       = req_reg;
        resp_next      = resp_reg;
        cow_page_next  = cow_page_reg;
        cow_cnt_next   = cow_cnt_reg;
        q_pop          = 1'b0;
        cnt_we         = 1'b0;
        cnt_waddr      = pidx;
        cnt_wdata      = c;
        cnt_re         = 1'b0;
        cnt_raddr      = qpidx;
        stk_we         = 1'b0;
        stk_waddr      = top_reg[IDX_W-1:0];
        stk_wdata      = pidx;
        stk_re         = 1'b0;
        stk_raddr      = top_m1[IDX_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we       = 1'b1;
                cnt_waddr    = clr_idx_reg;
                cnt_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // Pop a request, read its count and the top of the return stack
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cnt_re     = 1'b1;
                    stk_re     = 1'b1;
                    req_next   = q_req;
                    state_next = S_EXEC;
                end
            end

            // Decide, write back and load the result
            S_EXEC:
            begin
                if (go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    resp_next      = '0;
                    resp_next.status = ST_OK;
                    if (req_reg.bad)
                    begin
                        resp_next.status = ST_BAD;
                    end
                    else
                    begin
                        unique case (req_reg.cmd)
                            CMD_ALLOC:
                            begin
                                if (can_take)
                                begin
                                    cnt_we    = 1'b1;
                                    cnt_waddr = np;
                                    cnt_wdata = COUNT_WIDTH'(1);
                                    if (have_stack)
                                    begin
                                        top_next = top_m1;
                                    end
                                    else
                                    begin
                                        mark_next = mark_m1;
                                    end
                                    resp_next.result_page = np_page;
                                    resp_next.ref_count   = to_ref(COUNT_WIDTH'(1));
                                end
                                else
                                begin
                                    resp_next.status = ST_OOM;
                                end
                            end

                            CMD_FREE:
                            begin
                                if (c_zero)
                                begin
                                    resp_next.status = ST_NOTALLOC;
                                end
                                else
                                begin
                                    cnt_we    = 1'b1;
                                    cnt_wdata = c_dec;
                                    resp_next.ref_count = to_ref(c_dec);
                                    // Last reference gone: push onto the return stack
                                    if (c_dec == '0 && stack_room)
                                    begin
                                        stk_we   = 1'b1;
                                        top_next = top_reg + 1'b1;
                                        resp_next.page_released = 1'b1;
                                    end
                                end
                            end

                            CMD_ADDREF:
                            begin
                                resp_next.ref_count = to_ref(c);
                                if (c_zero)
                                begin
                                    resp_next.status = ST_NOTALLOC;
                                end
                                else if (c_max)
                                begin
                                    resp_next.status = ST_SAT;
                                end
                                else
                                begin
                                    cnt_we    = 1'b1;
                                    cnt_wdata = c_inc;
                                    resp_next.ref_count = to_ref(c_inc);
                                end
                            end

                            CMD_COW:
                            begin
                                resp_next.ref_count = to_ref(c);
                                if (c_le1)
                                begin
                                    resp_next.result_page = req_reg.page;
                                end
                                else if (can_take)
                                begin
                                    // New page first, old count written next cycle
                                    cnt_we    = 1'b1;
                                    cnt_waddr = np;
                                    cnt_wdata = COUNT_WIDTH'(1);
                                    if (have_stack)
                                    begin
                                        top_next = top_m1;
                                    end
                                    else
                                    begin
                                        mark_next = mark_m1;
                                    end
                                    cow_page_next = pidx;
                                    cow_cnt_next  = c_dec;
                                    state_next    = S_COW2;
                                    resp_next.result_page = np_page;
                                    resp_next.copy_needed = 1'b1;
                                    resp_next.ref_count   = to_ref(COUNT_WIDTH'(1));
                                end
                                else
                                begin
                                    resp_next.status = ST_OOM;
                                end
                            end

                            default:
                            begin
                                resp_next.status = ST_BAD;
                            end
                        endcase
                    end
                end
            end

            // Copy-on-write: decrement the old page's count
            S_COW2:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = cow_page_reg;
                cnt_wdata  = cow_cnt_reg;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            top_reg       <= '0;
            mark_reg      <= MARK_W'(NUM_PAGES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            top_reg       <= top_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        resp_reg     <= resp_next;
        cow_page_reg <= cow_page_next;
        cow_cnt_reg  <= cow_cnt_next;
    end

    assign clearing  = state_reg == S_CLEAR;
    assign out_valid = out_valid_reg;
    assign out_resp  = resp_reg;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the page allocator with reference counts.
module tb_top
    import pgalloc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PAGES = NUM_PAGES_DEF;
    localparam int CNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;

    // DUT connections
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PAGE_W-1:0]   cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CMD_W-1:0]    req_cmd = CMD_ALLOC;
    logic [PAGE_W-1:0]   req_page = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] rsp_status;
    logic [PAGE_W-1:0]   rsp_page;
    logic                rsp_copy;
    logic                rsp_released;
    logic [REF_W-1:0]    rsp_count;

    // Allocator image kept by the testbench
    int unsigned       page_refs [N_PAGES];
    logic [PAGE_W-1:0] freed_pages [$];
    int unsigned       fresh_mark;
    logic [PAGE_W-1:0] low_page;

    // Pages with a nonzero count, for picking well-formed requests
    logic [PAGE_W-1:0] live_list [$];
    int                live_pos [N_PAGES];

    pgalloc_resp_t     pending_results [$];
    pgalloc_resp_t     last_pred;
    int                results_seen = 0;
    int                n_mismatch = 0;
    bit                idle_on = 1'b1;
    bit                sink_idle_on = 1'b1;
    bit                calm = 1'b0;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] pg;
        bit                typed;
        pgalloc_resp_t     want;
    } dir_row_t;

    // Directed rows, run with first_page at 32764 so only four pages exist
    dir_row_t dir_rows [22] = '{
        '{CMD_ALLOC,  15'd0,     1'b1, '{ST_OK,       15'd32767, 1'b0, 1'b0, 8'd1}},
        '{CMD_ALLOC,  15'd32767, 1'b1, '{ST_OK,       15'd32766, 1'b0, 1'b0, 8'd1}},
        '{CMD_ALLOC,  15'd21845, 1'b1, '{ST_OK,       15'd32765, 1'b0, 1'b0, 8'd1}},
        '{CMD_ALLOC,  15'd10922, 1'b1, '{ST_OK,       15'd32764, 1'b0, 1'b0, 8'd1}},
        '{CMD_ALLOC,  15'd0,     1'b1, '{ST_OOM,      15'd0,     1'b0, 1'b0, 8'd0}},
        '{CMD_FREE,   15'd0,     1'b1, '{ST_BAD,      15'd0,     1'b0, 1'b0, 8'd0}},
        '{CMD_ADDREF, 15'd32767, 1'b1, '{ST_OK,       15'd0,     1'b0, 1'b0, 8'd2}},
        // copy-on-write with no page left keeps the old count
        '{CMD_COW,    15'd32767, 1'b1, '{ST_OOM,      15'd0,     1'b0, 1'b0, 8'd2}},
        '{CMD_COW,    15'd32766, 1'b1, '{ST_OK,       15'd32766, 1'b0, 1'b0, 8'd1}},
        '{CMD_FREE,   15'd32766, 1'b1, '{ST_OK,       15'd0,     1'b0, 1'b1, 8'd0}},
        // double free is flagged, page not pushed twice
        '{CMD_FREE,   15'd32766, 1'b1, '{ST_NOTALLOC, 15'd0,     1'b0, 1'b0, 8'd0}},
        '{CMD_ADDREF, 15'd32766, 1'b1, '{ST_NOTALLOC, 15'd0,     1'b0, 1'b0, 8'd0}},
        '{CMD_COW,    15'd32766, 1'b1, '{ST_OK,       15'd32766, 1'b0, 1'b0, 8'd0}},
        // shared page gets the returned page as its copy
        '{CMD_COW,    15'd32767, 1'b1, '{ST_OK,       15'd32766, 1'b1, 1'b0, 8'd1}},
        '{CMD_ALLOC,  15'd0,     1'b1, '{ST_OOM,      15'd0,     1'b0, 1'b0, 8'd0}},
        '{CMD_ADDREF, 15'd12345, 1'b1, '{ST_BAD,      15'd0,     1'b0, 1'b0, 8'd0}},
        '{CMD_COW,    15'd32763, 1'b1, '{ST_BAD,      15'd0,     1'b0, 1'b0, 8'd0}},
        '{CMD_FREE,   15'd32767, 1'b0, '0},
        '{CMD_ALLOC,  15'd0,     1'b0, '0},
        '{CMD_ADDREF, 15'd32765, 1'b0, '0},
        '{CMD_FREE,   15'd32765, 1'b0, '0},
        '{CMD_FREE,   15'd32764, 1'b0, '0}
    };

    page_allocator_with_ref_counts u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (req_cmd),
        .page          (req_page),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (rsp_status),
        .result_page   (rsp_page),
        .copy_needed   (rsp_copy),
        .page_released (rsp_released),
        .ref_count     (rsp_count)
    );

    always #5 clk = ~clk;

    // Track which pages currently hold a reference
    function automatic void set_live(logic [PAGE_W-1:0] pg, bit on);
        int                idx;
        logic [PAGE_W-1:0] last;
        if (on && live_pos[pg] < 0)
        begin
            live_pos[pg] = live_list.size();
            live_list.push_back(pg);
        end
        else if (!on && live_pos[pg] >= 0)
        begin
            idx = live_pos[pg];
            last = live_list[live_list.size()-1];
            live_list[idx] = last;
            live_pos[last] = idx;
            void'(live_list.pop_back());
            live_pos[pg] = -1;
        end
    endfunction

    // Returned pages first, then untouched pages from the top down
    function automatic bit grab_page(output logic [PAGE_W-1:0] pg);
        pg = '0;
        if (freed_pages.size() > 0)
        begin
            pg = freed_pages.pop_back();
            return 1'b1;
        end
        if (fresh_mark > low_page)
        begin
            fresh_mark--;
            pg = fresh_mark[PAGE_W-1:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one request to the allocator image and return its response
    function automatic pgalloc_resp_t apply_request(logic [CMD_W-1:0] cmd,
                                                    logic [PAGE_W-1:0] pg);
        pgalloc_resp_t     r;
        logic [PAGE_W-1:0] np;
        int unsigned       cnt;
        r = '0;
        cnt = 0;
        if (cmd == CMD_ALLOC)
        begin
            if (grab_page(np))
            begin
                page_refs[np] = 1;
                set_live(np, 1'b1);
                r.result_page = np;
                cnt = 1;
            end
            else
                r.status = ST_OOM;
        end
        else if (pg < low_page)
            r.status = ST_BAD;
        else if (cmd == CMD_FREE)
        begin
            if (page_refs[pg] == 0)
                r.status = ST_NOTALLOC;
            else
            begin
                page_refs[pg]--;
                cnt = page_refs[pg];
                if (cnt == 0)
                begin
                    set_live(pg, 1'b0);
                    if (freed_pages.size() < N_PAGES)
                    begin
                        freed_pages.push_back(pg);
                        r.page_released = 1'b1;
                    end
                end
            end
        end
        else if (cmd == CMD_ADDREF)
        begin
            cnt = page_refs[pg];
            if (cnt == 0)
                r.status = ST_NOTALLOC;
            else if (cnt >= CNT_MAX)
                r.status = ST_SAT;
            else
            begin
                cnt++;
                page_refs[pg] = cnt;
            end
        end
        else
        begin
            cnt = page_refs[pg];
            if (cnt <= 1)
                r.result_page = pg;
            else if (grab_page(np))
            begin
                page_refs[np] = 1;
                set_live(np, 1'b1);
                page_refs[pg] = cnt - 1;
                r.result_page = np;
                r.copy_needed = 1'b1;
                cnt = 1;
            end
            else
                r.status = ST_OOM;
        end
        r.ref_count = cnt[REF_W-1:0];
        return r;
    endfunction

    // Offer one request, with an optional idle gap in front of it
    task automatic send_req(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] pg,
                            bit typed, pgalloc_resp_t want);
        pgalloc_resp_t pred;
        if (idle_on && !calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_cmd <= cmd;
        req_page <= pg;
        do
            @(posedge clk);
        while (!in_ready);
        pred = apply_request(cmd, pg);
        last_pred = pred;
        pending_results.push_back(typed ? want : pred);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic set_first_page(logic [PAGE_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        low_page = value;
    endtask

    // Mostly well-formed traffic on live pages, some noise
    task automatic send_random(int count);
        int                sel;
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] pg;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                idle_on = ($urandom_range(0, 4) != 0);
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                cmd = CMD_W'($urandom_range(0, 3));
                pick = $urandom_range(0, 2);
                if (pick == 1 && low_page > 0)
                    pg = PAGE_W'($urandom_range(0, low_page - 1));
                else if (pick == 2 && freed_pages.size() > 0)
                    pg = freed_pages[$urandom_range(0, freed_pages.size() - 1)];
                else
                    pg = PAGE_W'($urandom_range(0, N_PAGES - 1));
            end
            else if (sel < 35 || live_list.size() == 0)
            begin
                cmd = CMD_ALLOC;
                pg = PAGE_W'($urandom_range(0, N_PAGES - 1));
            end
            else
            begin
                pg = live_list[$urandom_range(0, live_list.size() - 1)];
                if (sel < 60)
                    cmd = CMD_FREE;
                else if (sel < 80)
                    cmd = CMD_ADDREF;
                else
                    cmd = CMD_COW;
            end
            send_req(cmd, pg, 1'b0, '0);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        pgalloc_resp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: status %0d page %0d copy %0d rel %0d cnt %0d",
                             rsp_status, rsp_page, rsp_copy, rsp_released, rsp_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.status !== rsp_status || want.result_page !== rsp_page ||
                    want.copy_needed !== rsp_copy || want.page_released !== rsp_released ||
                    want.ref_count !== rsp_count)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                    begin
                        $write("result %0d mismatch: exp status %0d page %0d copy %0d ",
                               results_seen, want.status, want.result_page,
                               want.copy_needed);
                        $write("rel %0d cnt %0d, got status %0d page %0d copy %0d ",
                               want.page_released, want.ref_count,
                               rsp_status, rsp_page, rsp_copy);
                        $display("rel %0d cnt %0d", rsp_released, rsp_count);
                    end
                end
            end
        end
    end

    // Result side: random stall bursts plus one long hold-off
    initial
    begin : result_sink
        int hold_left;
        int stall_left;
        int cyc;
        bit hold_done;
        hold_left = 0;
        stall_left = 0;
        cyc = 0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
                sink_idle_on = ($urandom_range(0, 3) != 0);
            if (!hold_done && results_seen >= 60)
            begin
                hold_done = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (sink_idle_on && !calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Request side and run control
    initial
    begin : request_source
        logic [PAGE_W-1:0] hot;
        int unsigned       span;
        foreach (page_refs[i])
        begin
            page_refs[i] = 0;
            live_pos[i] = -1;
        end
        fresh_mark = N_PAGES;
        low_page = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on a four-page memory
        set_first_page(15'd32764);
        foreach (dir_rows[i])
            send_req(dir_rows[i].cmd, dir_rows[i].pg, dir_rows[i].typed, dir_rows[i].want);

        // full memory, with one page driven into saturation
        set_first_page(15'd0);
        send_random(200);
        send_req(CMD_ALLOC, '0, 1'b0, '0);
        hot = last_pred.result_page;
        repeat (257)
            send_req(CMD_ADDREF, hot, 1'b0, '0);
        send_req(CMD_COW, hot, 1'b0, '0);
        repeat (3)
            send_req(CMD_FREE, hot, 1'b0, '0);
        send_random(250);

        // top page only: nearly everything is out of range
        set_first_page(15'h7FFF);
        send_random(150);

        // a handful of untouched pages left, so allocation runs dry
        span = (fresh_mark > 20) ? fresh_mark - 20 : 0;
        set_first_page(PAGE_W'(span));
        send_random(400);

        // final stretch at full rate
        set_first_page(PAGE_W'($urandom_range(0, 64)));
        calm = 1'b1;
        send_random(450);

        drain();
        repeat (10) @(posedge clk);
        if (n_mismatch == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, far beyond the clearing pass and the slowest legal run
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
